FILE: sv/ip_address_public_classifier_macros.svh
// Assertion macros used by the address classifier RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef IP_ADDRESS_PUBLIC_CLASSIFIER_MACROS_SVH
`define IP_ADDRESS_PUBLIC_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while reset is asserted.
`define IPAPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define IPAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IPAPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define IPAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/ipapc_pkg.sv
`timescale 1ns / 1ps

package ipapc_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
	} req_t;

	typedef struct packed {
		logic loopback;
		logic routable;
	} rsp_t;

	localparam logic KIND_IPV4 = 1'b0;
	localparam logic KIND_IPV6 = 1'b1;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
	} v4_prefix_t;

	localparam int V4_RESERVED_N = 14;

	localparam v4_prefix_t V4_RESERVED [V4_RESERVED_N] = '{
		'{net: 32'h0000_0000, mask: 32'hff00_0000},  // this network
		'{net: 32'h0a00_0000, mask: 32'hff00_0000},  // private 10/8
		'{net: 32'h6440_0000, mask: 32'hffc0_0000},  // shared carrier-grade NAT
		'{net: 32'h7f00_0000, mask: 32'hff00_0000},  // loopback
		'{net: 32'ha9fe_0000, mask: 32'hffff_0000},  // link-local
		'{net: 32'hac10_0000, mask: 32'hfff0_0000},  // private 172.16/12
		'{net: 32'hc000_0000, mask: 32'hffff_ff00},  // protocol assignments
		'{net: 32'hc000_0200, mask: 32'hffff_ff00},  // TEST-NET-1
		'{net: 32'hc0a8_0000, mask: 32'hffff_0000},  // private 192.168/16
		'{net: 32'hc612_0000, mask: 32'hfffe_0000},  // benchmarking
		'{net: 32'hc633_6400, mask: 32'hffff_ff00},  // TEST-NET-2
		'{net: 32'hcb00_7100, mask: 32'hffff_ff00},  // TEST-NET-3
		'{net: 32'he000_0000, mask: 32'hf000_0000},  // multicast
		'{net: 32'hf000_0000, mask: 32'hf000_0000}   // reserved
	};

	localparam logic [31:0] V4_LOOP_NET  = 32'h7f00_0000;
	localparam logic [31:0] V4_LOOP_MASK = 32'hff00_0000;

	// Public unless any reserved prefix matches; the compares are independent.
	function automatic logic v4_public(input logic [31:0] a);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < V4_RESERVED_N; i++) begin
			if ((a & V4_RESERVED[i].mask) == V4_RESERVED[i].net) begin
				hit = 1'b1;
			end
		end
		return !hit;
	endfunction

endpackage

FILE: sv/ipapc_if.sv
`timescale 1ns / 1ps

interface ipapc_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;

	modport source (output valid, kind, addr_hi, addr_lo, input ready);
	modport sink (input valid, kind, addr_hi, addr_lo, output ready);
endinterface

interface ipapc_rsp_if;
	logic valid;
	logic ready;
	logic loopback;
	logic routable;

	modport source (output valid, loopback, routable, input ready);
	modport sink (input valid, loopback, routable, output ready);
endinterface

FILE: sv/ipapc_classify.sv
`timescale 1ns / 1ps

module ipapc_classify
	import ipapc_pkg::*;
(
	input  req_t item,
	output rsp_t res
);

	logic [31:0] v4_addr;
	logic [63:0] hi;
	logic [63:0] lo;
	logic [7:0]  b0, b1, b2, b3;
	logic [31:0] lo_top;
	logic        hi_zero;
	logic        v6_unspec, v6_loop;
	logic        v6_ula, v6_ll, v6_mc, v6_doc;
	logic        v6_embed, v6_global, v6_2001_rsvd, v6_6to4;
	logic        v4_emb_pub, v4_6to4_pub;
	logic        v6_pub;

	always_comb begin
		v4_addr = item.addr_lo[31:0];
		hi      = item.addr_hi;
		lo      = item.addr_lo;
		b0      = hi[63:56];
		b1      = hi[55:48];
		b2      = hi[47:40];
		b3      = hi[39:32];
		lo_top  = lo[63:32];
		hi_zero = (hi == 64'd0);

		v6_unspec = hi_zero && (lo == 64'd0);
		v6_loop   = hi_zero && (lo == 64'd1);
		v6_ula    = (b0[7:1] == 7'h7e);
		v6_ll     = (b0 == 8'hfe) && (b1[7:6] == 2'b10);
		v6_mc     = (b0 == 8'hff);
		v6_doc    = (hi[63:32] == 32'h2001_0db8);

		// mapped, compatible and NAT64 forms all carry IPv4 in the low word
		v6_embed = (hi_zero && ((lo_top == 32'h0000_ffff) || (lo_top == 32'd0)))
			|| ((hi == 64'h0064_ff9b_0000_0000) && (lo_top == 32'd0));
		v6_global    = (b0[7:5] == 3'b001);
		v6_2001_rsvd = (b0 == 8'h20) && (b1 == 8'h01) && (b2 == 8'h00)
			&& ((b3 == 8'h00) || (b3 == 8'h02) || (b3[7:4] == 4'h1) || (b3[7:4] == 4'h2));
		v6_6to4      = (hi[63:48] == 16'h2002);

		v4_emb_pub  = v4_public(lo[31:0]);
		v4_6to4_pub = v4_public(hi[47:16]);

		if (v6_unspec || v6_loop || v6_ula || v6_ll || v6_mc || v6_doc) begin
			v6_pub = 1'b0;
		end else if (v6_embed) begin
			v6_pub = v4_emb_pub;
		end else if (!v6_global || v6_2001_rsvd) begin
			v6_pub = 1'b0;
		end else if (v6_6to4) begin
			v6_pub = v4_6to4_pub;
		end else begin
			v6_pub = 1'b1;
		end

		if (item.kind == KIND_IPV4) begin
			res.loopback = ((v4_addr & V4_LOOP_MASK) == V4_LOOP_NET);
			res.routable = v4_emb_pub;
		end else begin
			res.loopback = v6_loop;
			res.routable = v6_pub;
		end
	end

endmodule

FILE: sv/ip_address_public_classifier.sv
// Address classifier: loopback and public flags for one IPv4 or IPv6 address.
// Each address is registered in stage 1, classified combinationally, and its flags
// are registered in stage 2, from which the result is offered.
// Throughput: one address per cycle unless rsp.ready stalls stage 2; both stages advance together when free.
// Reset: arst_n clears the stage valid flags at once; payload is not reset.
`timescale 1ns / 1ps
`include "ip_address_public_classifier_macros.svh"

module ip_address_public_classifier
	import ipapc_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	ipapc_req_if.sink     req,
	ipapc_rsp_if.source   rsp
);

	// Stage 1 holds the raw address; stage 2 holds the classified flags.
	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	rsp_t res_s2;
	rsp_t res_c;
	logic adv_s2;

	ipapc_classify u_classify (
		.item (item_s1),
		.res  (res_c)
	);

	// Stage 2 may load when empty or when its result is being taken this cycle.
	assign adv_s2 = !valid_s2 || rsp.ready;

	// Stage 1 may load when empty or when its item moves on to stage 2.
	assign req.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: capture on a free slot, hold otherwise.
	always_ff @(posedge clk) begin
		if (req.ready) begin
			item_s1.kind    <= req.kind;
			item_s1.addr_hi <= req.addr_hi;
			item_s1.addr_lo <= req.addr_lo;
		end
		if (adv_s2) begin
			res_s2 <= res_c;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.loopback = res_s2.loopback;
	assign rsp.routable = res_s2.routable;

	// A loopback address is never public.
	`IPAPC_ASSERT_IMPLY(a_loop_not_public, clk, arst_n, valid_s2,
		!(res_s2.loopback && res_s2.routable), "loopback flagged as public")

	// An input transfer must occupy stage 1 on the next cycle.
	`IPAPC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready,
		valid_s1, "accepted address lost before stage 1")

	// A stage 1 item that advances must appear in stage 2.
	`IPAPC_ASSERT_NEXT(a_s1_moves_to_s2, clk, arst_n, valid_s1 && adv_s2,
		valid_s2, "stage 1 item dropped on advance")

	// A delivered result with nothing behind it leaves stage 2 empty.
	`IPAPC_ASSERT_NEXT(a_drain_empties_s2, clk, arst_n, rsp.valid && rsp.ready && !valid_s1,
		!valid_s2, "result repeated after transfer")

endmodule
